### rtl/trs_pkg.sv
// Package: shared types, command codes and register indexes of the strip rasterizer.
`timescale 1ns / 1ps
package trs_pkg;

   localparam int BufferPixelsDefault = 5120;
   localparam int ScreenWidthDefault  = 320;
   localparam int ScreenHeightDefault = 480;

   localparam int CoordWidth = 12;
   localparam int RegWidth   = 9;
   localparam int ColorWidth = 16;

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_FILL  = 2'd1,
      CMD_READ  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      REG_STRIP_LEFT   = 3'd0,
      REG_STRIP_TOP    = 3'd1,
      REG_STRIP_WIDTH  = 3'd2,
      REG_STRIP_HEIGHT = 3'd3,
      REG_CLIP_LEFT    = 3'd4,
      REG_CLIP_TOP     = 3'd5,
      REG_CLIP_RIGHT   = 3'd6,
      REG_CLIP_BOTTOM  = 3'd7
   } reg_type;

   typedef struct packed {
      logic [RegWidth-1:0] strip_left;
      logic [RegWidth-1:0] strip_top;
      logic [RegWidth-1:0] strip_width;
      logic [RegWidth-1:0] strip_height;
      logic [RegWidth-1:0] clip_left;
      logic [RegWidth-1:0] clip_top;
      logic [RegWidth-1:0] clip_right;
      logic [RegWidth-1:0] clip_bottom;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ROWS,
      ST_AREA,
      ST_SETUP,
      ST_CLEAR,
      ST_WALK,
      ST_READ,
      ST_RDWAIT,
      ST_OUT
   } state_type;

   // Request to the pixel memory.
   typedef struct packed {
      logic                  wr_en;
      logic                  rd_en;
      logic [15:0]           addr;
      logic [ColorWidth-1:0] wdata;
   } mem_req_type;

endpackage

### rtl/triangle_rasterizer_strip_top.sv
// Top level of the strip-buffer triangle rasterizer.
// Usage:
//   req_* carries one command: clear the strip, fill a triangle or read a pixel.
//   rsp_* returns exactly one response per request: pixel_value and hit,
//   both zero except for a read that lands inside the strip.
//   csr_* writes one of eight 9-bit registers (strip origin/size, clip window);
//   write only while no request is in flight.
// Sequence:
//   Every request first counts the rows that fit the store, one subtract per
//   row (skipped when strip_width is zero). A clear then sizes the fill by
//   repeated add of strip_width per strip row and writes the pixels in order.
//   A triangle computes its area, sets up its clipped bounding box and then
//   walks every pixel of that box through the single memory port. A read
//   checks the address and, when it hits, waits for the memory data. The
//   response is then registered; one request is in work at a time.
// Reset:
//   State and configuration registers return to their reset values; the pixel
//   store is not cleared and holds nothing defined until written.
// Stall:
//   A response holds in its output register until rsp_tready; no new request
//   is taken meanwhile.
`timescale 1ns / 1ps
module triangle_rasterizer_strip_top #(
   parameter int BUFFER_PIXELS = trs_pkg::BufferPixelsDefault,
   parameter int SCREEN_WIDTH  = trs_pkg::ScreenWidthDefault,
   parameter int SCREEN_HEIGHT = trs_pkg::ScreenHeightDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // cmd[1:0], vert_a_x[13:2], vert_a_y[25:14], vert_b_x[37:26],
   // vert_b_y[49:38], vert_c_x[61:50], vert_c_y[73:62], color[89:74], zero pad
   input  logic [95:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // pixel_value[15:0], hit[16], zero pad
   output logic [23:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [8:0]  csr_data
);
   import trs_pkg::*;

   localparam int AW = $clog2(BUFFER_PIXELS);

   cfg_type cfg;
   logic mem_wr_en, mem_rd_en;
   logic [AW-1:0] mem_addr;
   logic [ColorWidth-1:0] mem_wdata, mem_rdata;

   trs_cfg u_cfg (
      .clock, .reset, .csr_valid, .csr_ready, .csr_index, .csr_data, .cfg
   );

   trs_engine #(
      .BUFFER_PIXELS(BUFFER_PIXELS), .SCREEN_WIDTH(SCREEN_WIDTH),
      .SCREEN_HEIGHT(SCREEN_HEIGHT), .AW(AW)
   ) u_engine (
      .clock, .reset, .cfg, .req_tvalid, .req_tready, .req_tdata(req_tdata[89:0]),
      .rsp_tvalid, .rsp_tready, .rsp_tdata,
      .mem_wr_en, .mem_rd_en, .mem_addr, .mem_wdata, .mem_rdata
   );

   trs_store #(.BUFFER_PIXELS(BUFFER_PIXELS), .AW(AW)) u_store (
      .clock, .wr_en(mem_wr_en), .rd_en(mem_rd_en), .addr(mem_addr),
      .wdata(mem_wdata), .rdata(mem_rdata)
   );

   // No new request while a response waits.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request accepted while response pending");

   // Response padding stays zero.
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[23:17] == 7'd0))
      else $error("response pad bits set");

   // A stalled response holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed under stall");
endmodule

### rtl/trs_store.sv
// Pixel store: single-port synchronous RGB565 memory with a registered read.
`timescale 1ns / 1ps
module trs_store #(
   parameter int BUFFER_PIXELS = trs_pkg::BufferPixelsDefault,
   parameter int AW            = $clog2(BUFFER_PIXELS)
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic                        rd_en,
   input  logic [AW-1:0]               addr,
   input  logic [trs_pkg::ColorWidth-1:0] wdata,
   output logic [trs_pkg::ColorWidth-1:0] rdata
);
   import trs_pkg::*;

   logic [ColorWidth-1:0] mem [BUFFER_PIXELS];
   logic [ColorWidth-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;
endmodule

### rtl/trs_cfg.sv
// Configuration register file of the strip rasterizer.
`timescale 1ns / 1ps
module trs_cfg (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [2:0]                 csr_index,
   input  logic [trs_pkg::RegWidth-1:0] csr_data,
   output trs_pkg::cfg_type           cfg
);
   import trs_pkg::*;

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (reg_type'(csr_index))
            REG_STRIP_LEFT:   cfg_in.strip_left   = csr_data;
            REG_STRIP_TOP:    cfg_in.strip_top    = csr_data;
            REG_STRIP_WIDTH:  cfg_in.strip_width  = csr_data;
            REG_STRIP_HEIGHT: cfg_in.strip_height = csr_data;
            REG_CLIP_LEFT:    cfg_in.clip_left    = csr_data;
            REG_CLIP_TOP:     cfg_in.clip_top     = csr_data;
            REG_CLIP_RIGHT:   cfg_in.clip_right   = csr_data;
            REG_CLIP_BOTTOM:  cfg_in.clip_bottom  = csr_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{strip_left: 9'd0, strip_top: 9'd0, strip_width: 9'd320,
                     strip_height: 9'd16, clip_left: 9'd0, clip_top: 9'd0,
                     clip_right: 9'd320, clip_bottom: 9'd480};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule

### rtl/trs_engine.sv
// Command sequencer: strip row count, bounding box setup, pixel walk, clear and read.
`timescale 1ns / 1ps
module trs_engine #(
   parameter int BUFFER_PIXELS = trs_pkg::BufferPixelsDefault,
   parameter int SCREEN_WIDTH  = trs_pkg::ScreenWidthDefault,
   parameter int SCREEN_HEIGHT = trs_pkg::ScreenHeightDefault,
   parameter int AW            = $clog2(BUFFER_PIXELS)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  trs_pkg::cfg_type      cfg,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [89:0]           req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [23:0]           rsp_tdata,
   output logic                  mem_wr_en,
   output logic                  mem_rd_en,
   output logic [AW-1:0]         mem_addr,
   output logic [trs_pkg::ColorWidth-1:0] mem_wdata,
   input  logic [trs_pkg::ColorWidth-1:0] mem_rdata
);
   import trs_pkg::*;

   localparam int CW = 14;   // signed working width for coordinates
   localparam int PW = 17;   // unsigned pixel count width (BUFFER_PIXELS <= 65536)

   state_type state_ff, state_in;

   logic [1:0]  cmd_ff;
   logic signed [CW-1:0] x0_ff, y0_ff, x1_ff, y1_ff, x2_ff, y2_ff;
   logic [ColorWidth-1:0] color_ff;
   logic [PW-1:0] rows_ff, rows_in;      // row count built by repeated subtract
   logic [PW-1:0] rem_ff, rem_in;
   logic signed [27:0] area_ff, area_in;
   logic signed [27:0] prod_a_ff, prod_b_ff;
   logic        area_step_ff, area_step_in;
   logic signed [CW-1:0] lox_ff, hix_ff, hiy_ff, x_ff, y_ff;
   logic signed [CW-1:0] lox_in, hix_in, hiy_in, x_in, y_in;
   logic [PW-1:0] cnt_ff, cnt_in, limit_ff, limit_in;
   logic [PW-1:0] row_base_ff, row_base_in;
   logic [15:0] pix_ff, pix_in;
   logic        hit_ff, hit_in;
   logic [AW-1:0] addr_in;
   logic wr_in, rd_in;

   // Edge function evaluation: one product pair per edge, computed combinationally for the current pixel.
   logic signed [27:0] e0, e1, e2;
   logic in_tri;

   function automatic logic signed [27:0] edge_val(
      input logic signed [CW-1:0] ax, ay, bx, by, qx, qy);
      logic signed [27:0] p, q;
      p = 28'(qx - ax) * 28'(by - ay);
      q = 28'(qy - ay) * 28'(bx - ax);
      return p - q;
   endfunction

   always_comb begin
      e0 = edge_val(x0_ff, y0_ff, x1_ff, y1_ff, x_ff, y_ff);
      e1 = edge_val(x1_ff, y1_ff, x2_ff, y2_ff, x_ff, y_ff);
      e2 = edge_val(x2_ff, y2_ff, x0_ff, y0_ff, x_ff, y_ff);
      if (area_ff > 0) in_tri = (e0 >= 0) && (e1 >= 0) && (e2 >= 0);
      else in_tri = (e0 <= 0) && (e1 <= 0) && (e2 <= 0);
   end

   function automatic logic signed [CW-1:0] smin(input logic signed [CW-1:0] a, b);
      return (a < b) ? a : b;
   endfunction
   function automatic logic signed [CW-1:0] smax(input logic signed [CW-1:0] a, b);
      return (a > b) ? a : b;
   endfunction

   logic signed [CW-1:0] sl, st, sw, rows_s, bx_lo, bx_hi, by_lo, by_hi;
   logic signed [CW-1:0] cl, ct, cr, cb;
   always_comb begin
      sl = CW'(signed'({1'b0, cfg.strip_left}));
      st = CW'(signed'({1'b0, cfg.strip_top}));
      sw = CW'(signed'({1'b0, cfg.strip_width}));
      rows_s = CW'(signed'({1'b0, rows_ff}));
      cl = CW'(signed'({1'b0, cfg.clip_left}));
      ct = CW'(signed'({1'b0, cfg.clip_top}));
      cr = CW'(signed'({1'b0, cfg.clip_right}));
      cb = CW'(signed'({1'b0, cfg.clip_bottom}));
      bx_lo = smax(smin(x0_ff, smin(x1_ff, x2_ff)), smax(cl, smax(sl, '0)));
      bx_hi = smin(smax(x0_ff, smax(x1_ff, x2_ff)) + CW'(1),
                   smin(cr, smin(sl + sw, CW'(SCREEN_WIDTH))));
      by_lo = smax(smin(y0_ff, smin(y1_ff, y2_ff)), smax(ct, smax(st, '0)));
      by_hi = smin(smax(y0_ff, smax(y1_ff, y2_ff)) + CW'(1),
                   smin(cb, smin(st + rows_s, CW'(SCREEN_HEIGHT))));
   end

   logic [PW-1:0] pix_idx;
   logic signed [CW-1:0] rx, ry;
   assign pix_idx = row_base_ff + PW'(unsigned'(x_ff - sl));
   assign rx = x0_ff;
   assign ry = y0_ff;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = {7'd0, hit_ff, pix_ff};

   always_comb begin
      state_in = state_ff;
      rows_in = rows_ff; rem_in = rem_ff; area_in = area_ff;
      area_step_in = area_step_ff;
      lox_in = lox_ff; hix_in = hix_ff; hiy_in = hiy_ff;
      x_in = x_ff; y_in = y_ff; cnt_in = cnt_ff; limit_in = limit_ff;
      row_base_in = row_base_ff;
      pix_in = pix_ff; hit_in = hit_ff;
      wr_in = 1'b0; rd_in = 1'b0; addr_in = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               rows_in = '0;
               rem_in = PW'(BUFFER_PIXELS);
               pix_in = '0; hit_in = 1'b0;
               area_step_in = 1'b0;
               state_in = (cfg.strip_width == '0) ? ST_AREA : ST_ROWS;
            end
         end
         ST_ROWS: begin
            // Count rows that fit the store, one subtract per cycle.
            if (rows_ff == PW'(cfg.strip_height) || rem_ff < PW'(cfg.strip_width)) begin
               state_in = ST_AREA;
            end else begin
               rem_in = rem_ff - PW'(cfg.strip_width);
               rows_in = rows_ff + PW'(1);
            end
         end
         ST_AREA: begin
            if (cmd_ff == CMD_CLEAR) begin
               cnt_in = '0;
               limit_in = '0;
               state_in = ST_SETUP;
            end else if (cmd_ff == CMD_READ) begin
               state_in = ST_READ;
            end else if (cmd_ff == CMD_FILL) begin
               if (!area_step_ff) begin
                  area_step_in = 1'b1;
               end else begin
                  area_in = prod_a_ff - prod_b_ff;
                  state_in = ST_SETUP;
               end
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_SETUP: begin
            if (cmd_ff == CMD_CLEAR) begin
               // limit = width * rows by repeated add
               if (cnt_ff == rows_ff) begin
                  cnt_in = '0;
                  state_in = (limit_ff == '0) ? ST_OUT : ST_CLEAR;
               end else begin
                  limit_in = limit_ff + PW'(cfg.strip_width);
                  cnt_in = cnt_ff + PW'(1);
               end
            end else begin
               lox_in = bx_lo; hix_in = bx_hi; hiy_in = by_hi;
               x_in = bx_lo; y_in = by_lo;
               row_base_in = PW'(unsigned'(by_lo - st)) * PW'(cfg.strip_width);
               if (area_ff == 0 || rows_ff == '0 || bx_lo >= bx_hi || by_lo >= by_hi)
                  state_in = ST_OUT;
               else state_in = ST_WALK;
            end
         end
         ST_CLEAR: begin
            wr_in = 1'b1;
            addr_in = AW'(cnt_ff);
            cnt_in = cnt_ff + PW'(1);
            if (cnt_in == limit_ff || cnt_in == PW'(BUFFER_PIXELS)) state_in = ST_OUT;
         end
         ST_WALK: begin
            if (in_tri && pix_idx < PW'(BUFFER_PIXELS)) begin
               wr_in = 1'b1;
               addr_in = AW'(pix_idx);
            end
            if (x_ff + CW'(1) >= hix_ff) begin
               x_in = lox_ff;
               y_in = y_ff + CW'(1);
               row_base_in = row_base_ff + PW'(cfg.strip_width);
               if (y_ff + CW'(1) >= hiy_ff) state_in = ST_OUT;
            end else begin
               x_in = x_ff + CW'(1);
            end
         end
         ST_READ: begin
            if (rx >= sl && rx < sl + sw && ry >= st && ry < st + rows_s &&
                (PW'(unsigned'(ry - st)) * PW'(cfg.strip_width) +
                 PW'(unsigned'(rx - sl))) < PW'(BUFFER_PIXELS)) begin
               rd_in = 1'b1;
               addr_in = AW'(PW'(unsigned'(ry - st)) * PW'(cfg.strip_width) +
                             PW'(unsigned'(rx - sl)));
               state_in = ST_RDWAIT;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_RDWAIT: begin
            pix_in = mem_rdata;
            hit_in = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_tvalid) begin
         cmd_ff   <= req_tdata[1:0];
         x0_ff    <= CW'(signed'(req_tdata[13:2]));
         y0_ff    <= CW'(signed'(req_tdata[25:14]));
         x1_ff    <= CW'(signed'(req_tdata[37:26]));
         y1_ff    <= CW'(signed'(req_tdata[49:38]));
         x2_ff    <= CW'(signed'(req_tdata[61:50]));
         y2_ff    <= CW'(signed'(req_tdata[73:62]));
         color_ff <= req_tdata[89:74];
      end
      // Area products, registered before the subtract.
      prod_a_ff <= 28'(x2_ff - x0_ff) * 28'(y1_ff - y0_ff);
      prod_b_ff <= 28'(y2_ff - y0_ff) * 28'(x1_ff - x0_ff);
      rows_ff <= rows_in; rem_ff <= rem_in; area_ff <= area_in;
      area_step_ff <= area_step_in;
      lox_ff <= lox_in; hix_ff <= hix_in; hiy_ff <= hiy_in;
      x_ff <= x_in; y_ff <= y_in; cnt_ff <= cnt_in; limit_ff <= limit_in;
      row_base_ff <= row_base_in;
      pix_ff <= pix_in; hit_ff <= hit_in;
   end

   assign mem_wr_en = wr_in;
   assign mem_rd_en = rd_in;
   assign mem_addr  = addr_in;
   assign mem_wdata = color_ff;
endmodule
